/* rtl/bsfr_pkg.sv */
// Shared types and constants for the byte-stuffed frame receiver.
`default_nettype none
package bsfr_pkg;

	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_START  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_STOP   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ESCAPE = 2'd2;

	localparam int unsigned DESC_DEPTH = 2;
	localparam int unsigned OUT_DEPTH  = 4;
	localparam int unsigned OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
	localparam int unsigned OUT_W      = 10;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] stop_byte;
		logic [7:0] escape_byte;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

endpackage
`default_nettype wire

/* rtl/bsfr_fifo.sv */
// Small register-based first-in first-out queue.
`default_nettype none
module bsfr_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       pop,
	output logic [WIDTH-1:0]                rd_data,
	output logic                            full,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rd_data = store_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

/* rtl/bsfr_front.sv */
// Front end: classifies received bytes, unescapes them and fills the frame banks.
`default_nettype none
module bsfr_front #(
	parameter int unsigned FRAME_BYTES = 32,
	parameter int unsigned CNT_W       = $clog2(FRAME_BYTES + 1),
	parameter int unsigned IDX_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic [7:0]            rx_byte,
	output logic                       full,
	input  wire bsfr_pkg::cfg_t        cfg,
	input  wire bsfr_pkg::bank_rel_t   rel,
	input  wire logic                  desc_full,
	output logic                       desc_push,
	output logic [CNT_W:0]             desc_data,
	output logic                       mem_we,
	output logic [IDX_W:0]             mem_addr,
	output logic [7:0]                 mem_data
);
	import bsfr_pkg::*;

	logic             in_frame_q;
	logic             armed_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_bank_q;
	logic [1:0]       busy_q;
	logic             accept;
	logic             is_esc;
	logic             is_start;
	logic             is_stop;
	logic             is_data;
	logic [7:0]       data_byte;
	logic             at_limit;

	assign full      = busy_q[wr_bank_q] || desc_full;
	assign accept    = push && !full;
	assign is_esc    = (rx_byte == cfg.escape_byte);
	assign is_start  = !is_esc && (rx_byte == cfg.start_byte);
	assign is_stop   = !is_esc && !is_start && (rx_byte == cfg.stop_byte);
	assign is_data   = !is_esc && !is_start && !is_stop;
	assign data_byte = armed_q ? (rx_byte ^ cfg.escape_byte) : rx_byte;
	assign at_limit  = (count_q == CNT_W'(FRAME_BYTES));

	assign desc_push = accept && is_stop && in_frame_q;
	assign desc_data = {wr_bank_q, count_q};
	assign mem_we    = accept && is_data && in_frame_q && !at_limit;
	assign mem_addr  = {wr_bank_q, count_q[IDX_W-1:0]};
	assign mem_data  = data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			armed_q    <= 1'b0;
			count_q    <= '0;
			wr_bank_q  <= 1'b0;
			busy_q     <= '0;
		end else begin
			if (rel.valid) begin
				busy_q[rel.bank] <= 1'b0;
			end
			if (accept) begin
				if (is_esc) begin
					armed_q <= 1'b1;
				end else if (is_start) begin
					in_frame_q <= 1'b1;
					armed_q    <= 1'b0;
					count_q    <= '0;
				end else if (is_stop) begin
					if (in_frame_q && count_q != '0) begin
						busy_q[wr_bank_q] <= 1'b1;
						wr_bank_q         <= !wr_bank_q;
					end
					in_frame_q <= 1'b0;
					armed_q    <= 1'b0;
				end else begin
					armed_q <= 1'b0;
					if (in_frame_q) begin
						if (at_limit) begin
							in_frame_q <= 1'b0;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/bsfr_back.sv */
// Back end: holds the two frame banks and drains completed frames as result words.
`default_nettype none
module bsfr_back #(
	parameter int unsigned FRAME_BYTES = 32,
	parameter int unsigned CNT_W       = $clog2(FRAME_BYTES + 1),
	parameter int unsigned IDX_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           mem_we,
	input  wire logic [IDX_W:0]                 mem_addr,
	input  wire logic [7:0]                     mem_data,
	input  wire logic                           desc_empty,
	input  wire logic [CNT_W:0]                 desc_data,
	output logic                                desc_pop,
	input  wire logic [bsfr_pkg::OUT_CNT_W-1:0] out_cnt,
	output logic                                out_push,
	output logic [bsfr_pkg::OUT_W-1:0]          out_data,
	output bsfr_pkg::bank_rel_t                 rel
);
	import bsfr_pkg::*;

	localparam int unsigned MEM_DEPTH = 2 ** (IDX_W + 1);

	logic [7:0]       mem [MEM_DEPTH];
	logic             active_q;
	logic             bank_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] idx_q;
	logic             valid_s1;
	logic             last_s1;
	logic             empty_s1;
	logic [7:0]       rd_data_s1;
	logic             room;
	logic             issue;
	logic             is_empty;
	logic             is_last;

	assign room     = (out_cnt + OUT_CNT_W'(valid_s1)) < OUT_CNT_W'(OUT_DEPTH);
	assign issue    = active_q && room;
	assign is_empty = (len_q == '0);
	assign is_last  = is_empty || ((idx_q + CNT_W'(1)) == len_q);
	assign desc_pop = !active_q && !desc_empty;

	assign rel.valid = issue && is_last && !is_empty;
	assign rel.bank  = bank_q;

	assign out_push = valid_s1;
	assign out_data = {(empty_s1 ? 8'h00 : rd_data_s1), last_s1, empty_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (desc_pop) begin
				active_q <= 1'b1;
			end else if (issue && is_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc_pop) begin
			bank_q <= desc_data[CNT_W];
			len_q  <= desc_data[CNT_W-1:0];
			idx_q  <= '0;
		end else if (issue) begin
			idx_q <= idx_q + 1'b1;
		end
		if (issue) begin
			last_s1    <= is_last;
			empty_s1   <= is_empty;
			rd_data_s1 <= mem[{bank_q, idx_q[IDX_W-1:0]}];
		end
		if (mem_we) begin
			mem[mem_addr] <= mem_data;
		end
	end

endmodule
`default_nettype wire

/* rtl/byte_stuffed_frame_receiver.sv */
// Top level of the byte-stuffed frame receiver with its register port.
// Received bytes are taken one per cycle while full is low and unescaped into one of two
// frame banks of FRAME_BYTES bytes each; a stop byte hands the filled bank to the drain
// side, which presents the frame's bytes as result words, one per cycle as long as the
// output queue has room, as the next frame fills the other bank. The input side raises
// full only when the bank it would fill next still waits to be drained, or the two-entry
// frame queue between the sides is full, so a frame stalls input only if it ends before
// the frame ahead of it has been read out. An empty frame yields one word with
// empty_frame set. A four-word output queue decouples the drain from pop.
`default_nettype none
module byte_stuffed_frame_receiver #(
	parameter int unsigned FRAME_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        push,
	input  wire logic [7:0]  rx_byte,
	output logic             full,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       payload_byte,
	output logic             last_byte,
	output logic             empty_frame
);
	import bsfr_pkg::*;

	localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
	localparam int unsigned IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

	cfg_t                 cfg_q;
	bank_rel_t            rel;
	logic                 desc_push;
	logic                 desc_pop;
	logic                 desc_full;
	logic                 desc_empty;
	logic [CNT_W:0]       desc_wr;
	logic [CNT_W:0]       desc_rd;
	logic [$clog2(DESC_DEPTH+1)-1:0] desc_cnt;
	logic                 mem_we;
	logic [IDX_W:0]       mem_addr;
	logic [7:0]           mem_data;
	logic                 out_push;
	logic [OUT_W-1:0]     out_wr;
	logic [OUT_W-1:0]     out_rd;
	logic                 out_full;
	logic [OUT_CNT_W-1:0] out_cnt;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte  <= 8'd126;
			cfg_q.stop_byte   <= 8'd127;
			cfg_q.escape_byte <= 8'd125;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_START:  cfg_q.start_byte  <= pwdata[7:0];
				REG_STOP:   cfg_q.stop_byte   <= pwdata[7:0];
				REG_ESCAPE: cfg_q.escape_byte <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_START:  prdata = {24'd0, cfg_q.start_byte};
			REG_STOP:   prdata = {24'd0, cfg_q.stop_byte};
			REG_ESCAPE: prdata = {24'd0, cfg_q.escape_byte};
			default:    prdata = 32'd0;
		endcase
	end

	bsfr_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rx_byte   (rx_byte),
		.full      (full),
		.cfg       (cfg_q),
		.rel       (rel),
		.desc_full (desc_full),
		.desc_push (desc_push),
		.desc_data (desc_wr),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_data  (mem_data)
	);

	bsfr_fifo #(
		.WIDTH(CNT_W + 1),
		.DEPTH(DESC_DEPTH)
	) u_desc_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (desc_push),
		.wr_data (desc_wr),
		.pop     (desc_pop),
		.rd_data (desc_rd),
		.full    (desc_full),
		.empty   (desc_empty),
		.count   (desc_cnt)
	);

	bsfr_back #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mem_we     (mem_we),
		.mem_addr   (mem_addr),
		.mem_data   (mem_data),
		.desc_empty (desc_empty),
		.desc_data  (desc_rd),
		.desc_pop   (desc_pop),
		.out_cnt    (out_cnt),
		.out_push   (out_push),
		.out_data   (out_wr),
		.rel        (rel)
	);

	bsfr_fifo #(
		.WIDTH(OUT_W),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (out_push),
		.wr_data (out_wr),
		.pop     (pop),
		.rd_data (out_rd),
		.full    (out_full),
		.empty   (empty),
		.count   (out_cnt)
	);

	assign payload_byte = out_rd[OUT_W-1:2];
	assign last_byte    = out_rd[1];
	assign empty_frame  = out_rd[0];

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result word pushed into a full output queue");

	a_desc_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		desc_push |-> (!desc_full && desc_cnt < 2'(DESC_DEPTH)))
		else $error("frame handed over while the frame queue is full");

	a_empty_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && empty_frame) |-> (last_byte && payload_byte == 8'h00))
		else $error("empty-frame word without last mark or with nonzero data");

endmodule
`default_nettype wire
